// ===== src/bpfa_pkg.sv =====
// ----------------------------------------------------------------------------
// bpfa_pkg
// Shared types and constants of the bitmap page frame allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bpfa_pkg;

  localparam int PAGE_BYTES    = 4096;
  localparam int PAGE_LOG2     = $clog2(PAGE_BYTES);
  localparam int FRAME_COUNT   = 262144;
  localparam int MAP_WORD_BITS = 64;

  localparam logic [18:0] FRAME_LIMIT_RST  = 19'd229376;
  localparam logic [17:0] NORMAL_GOAL_RST  = 18'd4096;
  localparam logic [17:0] LOW_GOAL_RST     = 18'd0;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_RESERVE = 2'd1,
    OP_FREE    = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOMEM    = 2'd1,
    ST_DBLFREE  = 2'd2,
    ST_ZEROSIZE = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    REG_FRAME_LIMIT = 2'd0,
    REG_NORMAL_GOAL = 2'd1,
    REG_LOW_GOAL    = 2'd2,
    REG_UNUSED      = 2'd3
  } cfg_reg_e;

endpackage

`default_nettype wire

// ===== src/bitmap_page_frame_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// bitmap_page_frame_allocator_unit
// First-fit page frame allocator over a one-bit-per-frame map held in RAM.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | contents
//  --------+-----------+------------------------+------------------------------
//  cfg     | in        | cfg_valid_i/cfg_ready_o | register index, write data
//  in      | in        | in_valid_i/in_ready_o   | one allocate/reserve/free request
//  out     | out       | out_valid_o/out_ready_i | status, address, fault frame
//
//  One request at a time. A request walks its frames one per cycle while the
//  frame's map word is held; a map word not yet held is read and then loaded,
//  once any dirty held word is written back. An allocate walks from the goal
//  to the end of the found run, then once more over the block.
//  Reset: a clearing pass writes zero to every map word, one a cycle
//  (MAP_WORDS words, 4096 by default); no request is taken until it ends.
//  Stalls: a result waits in the output register; the next request is taken
//  meanwhile and holds in its final step until the register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_page_frame_allocator_unit #(
  parameter int FRAME_COUNT   = bpfa_pkg::FRAME_COUNT,
  parameter int MAP_WORD_BITS = bpfa_pkg::MAP_WORD_BITS
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [18:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  operation_i,
  input  wire logic [29:0] byte_address_i,
  input  wire logic [30:0] byte_count_i,
  input  wire logic        low_zone_i,
  input  wire logic        page_aligned_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       status_o,
  output logic [29:0]      alloc_address_o,
  output logic [17:0]      fault_frame_o
);

  import bpfa_pkg::*;

  localparam int MAP_WORDS = (FRAME_COUNT + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int WAW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int BW  = $clog2(MAP_WORD_BITS);
  localparam int FW  = $clog2(FRAME_COUNT) + 1;   // holds FRAME_COUNT itself
  localparam int NW  = 32 - PAGE_LOG2;            // page counts of a 32-bit size
  localparam int LFW = 33 - PAGE_LOG2;            // last frame of an allocation
  localparam logic [32:0] FRAME_COUNT33 = 33'(FRAME_COUNT);
  localparam logic [32:0] PAGE_M1       = 33'(PAGE_BYTES - 1);
  localparam logic [WAW-1:0] LAST_WORD  = WAW'(MAP_WORDS - 1);

  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_RUN, S_WAIT, S_PACK, S_FLUSH, S_OUT
  } state_e;

  typedef enum logic [1:0] {
    M_MARK, M_FREE, M_ALLOC
  } mode_e;

  state_e state_q;
  mode_e  mode_q;

  // configuration
  logic [18:0] frame_limit_q;
  logic [17:0] normal_goal_q, low_goal_q;

  // walk state
  logic [FW-1:0]  f_q, hi_q, block_q;
  logic [NW-1:0]  need_q, found_q;
  logic [30:0]    count_q;
  logic           aligned_q;
  logic [WAW-1:0] clr_q;

  // word cache
  logic [MAP_WORD_BITS-1:0] word_q;
  logic [WAW-1:0]           word_idx_q;
  logic                     word_vld_q, dirty_q;

  // allocation history
  logic [LFW-1:0]       last_frame_q;
  logic [PAGE_LOG2-1:0] last_fill_q;

  // result being built and the output register
  logic [1:0]  res_st_q;
  logic [29:0] res_addr_q;
  logic [17:0] res_fault_q;
  logic        out_vld_q;
  logic [1:0]  out_st_q;
  logic [29:0] out_addr_q;
  logic [17:0] out_fault_q;
  logic        out_load;

  // memory port
  logic                     ram_we, ram_re;
  logic [WAW-1:0]           ram_waddr, ram_raddr;
  logic [MAP_WORD_BITS-1:0] ram_wdata, ram_rdata;

  bpfa_map_ram #(
    .WORDS (MAP_WORDS),
    .WIDTH (MAP_WORD_BITS),
    .AW    (WAW)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // Range setup arithmetic
  // --------------------------------------------------------------------------
  logic [32:0] lim33, addr33, cnt33;
  logic [32:0] mark_lo, mark_hi_raw, free_lo, free_hi_raw, goal33;
  logic [32:0] mark_hi, free_hi;
  logic [FW-1:0] lim_f;
  logic [FW-1:0] f_word_sh;
  logic [WAW-1:0] f_word;
  logic [BW-1:0]  f_bit;
  logic           f_bitval;

  assign lim33  = (33'(frame_limit_q) > FRAME_COUNT33) ? FRAME_COUNT33 : 33'(frame_limit_q);
  assign lim_f  = lim33[FW-1:0];
  assign addr33 = 33'(byte_address_i);
  assign cnt33  = 33'(byte_count_i);
  assign goal33 = 33'(low_zone_i ? low_goal_q : normal_goal_q);

  assign mark_lo     = addr33 >> PAGE_LOG2;
  assign mark_hi_raw = (addr33 + cnt33 + PAGE_M1) >> PAGE_LOG2;
  assign mark_hi     = (mark_hi_raw > lim33) ? lim33 : mark_hi_raw;
  assign free_lo     = (addr33 + PAGE_M1) >> PAGE_LOG2;
  assign free_hi_raw = (addr33 + cnt33) >> PAGE_LOG2;
  assign free_hi     = (free_hi_raw > lim33) ? lim33 : free_hi_raw;

  // packing of an allocation into the last page of the previous one
  logic [32:0]    blk_addr, pk_addr, pk_end, pk_lo, pk_hi_raw, pk_hi, pk_last;
  logic           pk_take;
  assign blk_addr  = 33'(block_q) << PAGE_LOG2;
  assign pk_take   = (33'(block_q) == 33'(last_frame_q) + 33'd1) &&
                     (last_fill_q != '0) && !aligned_q;
  assign pk_addr   = pk_take ? blk_addr - 33'(PAGE_BYTES) + 33'(last_fill_q) : blk_addr;
  assign pk_end    = pk_addr + 33'(count_q);
  assign pk_last   = (pk_end - 33'd1) >> PAGE_LOG2;
  assign pk_lo     = pk_addr >> PAGE_LOG2;
  assign pk_hi_raw = (pk_end + PAGE_M1) >> PAGE_LOG2;
  assign pk_hi     = (pk_hi_raw > lim33) ? lim33 : pk_hi_raw;

  assign f_word_sh = f_q >> BW;
  assign f_word    = f_word_sh[WAW-1:0];
  assign f_bit     = f_q[BW-1:0];
  assign f_bitval  = word_q[f_bit];

  logic word_hit;
  assign word_hit = word_vld_q && (word_idx_q == f_word);

  // --------------------------------------------------------------------------
  // Memory port selection
  // --------------------------------------------------------------------------
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = word_idx_q;
    ram_wdata = word_q;
    ram_re    = 1'b0;
    ram_raddr = f_word;
    case (state_q)
      S_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
      end
      S_RUN: begin
        if (f_q < hi_q && !word_hit) begin
          ram_we = dirty_q;
          ram_re = !dirty_q;
        end
      end
      S_FLUSH: ram_we = dirty_q;
      default: ;
    endcase
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;

  // load the output register from the final step once it is free
  assign out_load = (state_q == S_OUT) && (!out_vld_q || out_ready_i);

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_CLR;
      mode_q        <= M_MARK;
      clr_q         <= '0;
      word_vld_q    <= 1'b0;
      dirty_q       <= 1'b0;
      last_frame_q  <= '0;
      last_fill_q   <= '0;
      out_vld_q     <= 1'b0;
      frame_limit_q <= FRAME_LIMIT_RST;
      normal_goal_q <= NORMAL_GOAL_RST;
      low_goal_q    <= LOW_GOAL_RST;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_FRAME_LIMIT: frame_limit_q <= cfg_data_i;
          REG_NORMAL_GOAL: normal_goal_q <= cfg_data_i[17:0];
          REG_LOW_GOAL:    low_goal_q    <= cfg_data_i[17:0];
          default: ;
        endcase
      end

      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_vld_q && out_ready_i) begin
        out_vld_q <= 1'b0;
      end

      case (state_q)
        S_CLR: begin
          clr_q <= clr_q + WAW'(1);
          if (clr_q == LAST_WORD) begin
            state_q <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (in_valid_i) begin
            res_st_q    <= (operation_i == OP_ALLOC && byte_count_i == '0) ?
                           ST_ZEROSIZE : ST_OK;
            res_addr_q  <= '0;
            res_fault_q <= '0;
            count_q     <= byte_count_i;
            aligned_q   <= page_aligned_i;
            case (operation_i)
              OP_ALLOC: begin
                if (byte_count_i == '0) begin
                  state_q  <= S_OUT;
                end else begin
                  mode_q  <= M_ALLOC;
                  need_q  <= NW'((cnt33 + PAGE_M1) >> PAGE_LOG2);
                  found_q <= '0;
                  hi_q    <= lim_f;
                  f_q     <= (goal33 < lim33) ? goal33[FW-1:0] : lim_f;
                  block_q <= (goal33 < lim33) ? goal33[FW-1:0] : lim_f;
                  state_q <= S_RUN;
                end
              end
              OP_RESERVE: begin
                mode_q  <= M_MARK;
                hi_q    <= mark_hi[FW-1:0];
                f_q     <= (mark_lo < mark_hi) ? mark_lo[FW-1:0] : mark_hi[FW-1:0];
                state_q <= S_RUN;
              end
              OP_FREE: begin
                mode_q  <= M_FREE;
                hi_q    <= free_hi[FW-1:0];
                f_q     <= (free_lo < free_hi) ? free_lo[FW-1:0] : free_hi[FW-1:0];
                state_q <= S_RUN;
              end
              default: state_q <= S_OUT;
            endcase
          end
        end

        S_RUN: begin
          if (f_q >= hi_q) begin
            // run off the end: an allocate that gets here found nothing
            if (mode_q == M_ALLOC) begin
              res_st_q <= ST_NOMEM;
            end
            state_q <= S_FLUSH;
          end else if (!word_hit) begin
            if (dirty_q) begin
              dirty_q <= 1'b0;
            end else begin
              state_q <= S_WAIT;
            end
          end else begin
            case (mode_q)
              M_MARK: begin
                word_q[f_bit] <= 1'b1;
                dirty_q       <= 1'b1;
                f_q           <= f_q + FW'(1);
              end
              M_FREE: begin
                if (!f_bitval) begin
                  res_st_q    <= ST_DBLFREE;
                  res_fault_q <= 18'(f_q);
                  state_q     <= S_FLUSH;
                end else begin
                  word_q[f_bit] <= 1'b0;
                  dirty_q       <= 1'b1;
                  f_q           <= f_q + FW'(1);
                end
              end
              default: begin
                f_q <= f_q + FW'(1);
                if (f_bitval) begin
                  block_q <= f_q + FW'(1);
                  found_q <= '0;
                end else begin
                  found_q <= found_q + NW'(1);
                  if (found_q + NW'(1) >= need_q) begin
                    state_q <= S_PACK;
                  end
                end
              end
            endcase
          end
        end

        S_WAIT: begin
          word_q     <= ram_rdata;
          word_idx_q <= f_word;
          word_vld_q <= 1'b1;
          state_q    <= S_RUN;
        end

        S_PACK: begin
          // settle the address, then mark the block like a reserve
          res_addr_q   <= pk_addr[29:0];
          last_frame_q <= pk_last[LFW-1:0];
          last_fill_q  <= pk_end[PAGE_LOG2-1:0];
          mode_q       <= M_MARK;
          hi_q         <= pk_hi[FW-1:0];
          f_q          <= (pk_lo < pk_hi) ? pk_lo[FW-1:0] : pk_hi[FW-1:0];
          state_q      <= S_RUN;
        end

        S_FLUSH: begin
          dirty_q <= 1'b0;
          state_q <= S_OUT;
        end

        S_OUT: begin
          if (out_load) begin
            out_st_q    <= res_st_q;
            out_addr_q  <= res_addr_q;
            out_fault_q <= res_fault_q;
            state_q     <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o     = out_vld_q;
  assign status_o        = out_st_q;
  assign alloc_address_o = out_addr_q;
  assign fault_frame_o   = out_fault_q;

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  a_no_rw_same_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("map read and write issued together");

  a_dirty_needs_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dirty_q |-> word_vld_q)
    else $error("dirty cache word without a loaded word");

  a_clean_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !dirty_q)
    else $error("modified map word left unwritten at end of request");

  a_one_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second request taken while one is in progress");

endmodule

`default_nettype wire

// ===== src/bpfa_map_ram.sv =====
// ----------------------------------------------------------------------------
// bpfa_map_ram
// Single-port-write, single-port-read frame map store, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bpfa_map_ram #(
  parameter int WORDS = 4096,
  parameter int WIDTH = 64,
  parameter int AW    = 12
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [WORDS];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire
